/* sv/ice_cycle_controller_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ice cycle controller
// ---------------------------------------------------------------------------
`ifndef ICE_CYCLE_CONTROLLER_CORE_DEFINES_SVH
`define ICE_CYCLE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ICC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ice cycle controller: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ICC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ice cycle controller: next-cycle check failed");

`endif

/* sv/icc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icc_pkg
// Types, constants and helpers shared by the ice cycle controller.
// ---------------------------------------------------------------------------
package icc_pkg;

   // Width of the minute counter and the fill start mark.
   localparam int TIMER_WIDTH = 8;
   // Compare width: one bit above the wider of timer and config values.
   localparam int CMP_WIDTH   = ((TIMER_WIDTH > 8) ? TIMER_WIDTH : 8) + 1;

   localparam int CFG_WIDTH   = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int MIN_OUT_W   = 8;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [CMP_WIDTH-1:0]   cmp_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_val_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAKING_MINUTES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREEZE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_START_DELAY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_TIMEOUT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_TIMEOUT     = 3'd4;

   // Reset values of the configuration registers.
   localparam cfg_val_type RST_MAKING_MINUTES   = 8'd45;
   localparam cfg_val_type RST_FREEZE_THRESHOLD = 8'h50;
   localparam cfg_val_type RST_FILL_START_DELAY = 8'd10;
   localparam cfg_val_type RST_FILL_TIMEOUT     = 8'd30;
   localparam cfg_val_type RST_DROP_TIMEOUT     = 8'd15;

   typedef enum logic [2:0] {
      MODE_OFF     = 3'd0,
      MODE_INIT    = 3'd1,
      MODE_MAKING  = 3'd2,
      MODE_RELEASE = 3'd3,
      MODE_NOWATER = 3'd4
   } mode_type;

   // Bit positions in the actuator vector.
   localparam int ACT_COMP = 0;
   localparam int ACT_PUMP = 1;
   localparam int ACT_FAN  = 2;
   localparam int ACT_HEAT = 3;
   localparam int ACT_RES  = 4;
   localparam int ACT_LED  = 5;
   localparam int ACT_W    = 6;

   typedef logic [ACT_W-1:0] act_type;

   typedef struct packed {
      cfg_val_type making_minutes;
      cfg_val_type freeze_threshold;
      cfg_val_type fill_start_delay;
      cfg_val_type fill_timeout;
      cfg_val_type drop_timeout;
   } cfg_type;

   typedef struct packed {
      logic        minute_tick;
      logic        ice_fall;
      logic        power_press;
      logic        tank_full;
      logic [7:0]  low_side_temp;
   } req_type;

   typedef struct packed {
      mode_type    mode;
      timer_type   minutes;
      timer_type   fill_start;
      logic        fall_flag;
      act_type     act;
   } state_type;

   function automatic cmp_type ext_timer(timer_type t);
      return CMP_WIDTH'(t);
   endfunction

   function automatic cmp_type ext_cfg(cfg_val_type v);
      return CMP_WIDTH'(v);
   endfunction

   // Low bits of the counter for the result port.
   function automatic logic [MIN_OUT_W-1:0] minutes_out(timer_type t);
      cmp_type wide;
      wide = CMP_WIDTH'(t);
      return wide[MIN_OUT_W-1:0];
   endfunction

endpackage

/* sv/icc_csr.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icc_csr
// Configuration registers, written through a plain enable/index/data port.
// ---------------------------------------------------------------------------
module icc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [icc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [icc_pkg::CFG_WIDTH-1:0]    csr_wdata,
   output icc_pkg::cfg_type                 cfg
);

   icc_pkg::cfg_type cfg_ff;
   icc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            icc_pkg::CSR_MAKING_MINUTES:   cfg_in.making_minutes   = csr_wdata;
            icc_pkg::CSR_FREEZE_THRESHOLD: cfg_in.freeze_threshold = csr_wdata;
            icc_pkg::CSR_FILL_START_DELAY: cfg_in.fill_start_delay = csr_wdata;
            icc_pkg::CSR_FILL_TIMEOUT:     cfg_in.fill_timeout     = csr_wdata;
            icc_pkg::CSR_DROP_TIMEOUT:     cfg_in.drop_timeout     = csr_wdata;
            default:                       cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.making_minutes   <= icc_pkg::RST_MAKING_MINUTES;
         cfg_ff.freeze_threshold <= icc_pkg::RST_FREEZE_THRESHOLD;
         cfg_ff.fill_start_delay <= icc_pkg::RST_FILL_START_DELAY;
         cfg_ff.fill_timeout     <= icc_pkg::RST_FILL_TIMEOUT;
         cfg_ff.drop_timeout     <= icc_pkg::RST_DROP_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/icc_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icc_step
// Next-state logic of one control pass: events, mode logic, tank fill.
// ---------------------------------------------------------------------------
module icc_step (
   input  icc_pkg::cfg_type    cfg,
   input  icc_pkg::state_type  cur,
   input  icc_pkg::req_type    req,
   output icc_pkg::state_type  nxt
);

   icc_pkg::mode_type  md;
   icc_pkg::timer_type mc;
   icc_pkg::timer_type fs;
   icc_pkg::cmp_type   fs_sum;
   icc_pkg::cmp_type   fill_limit;
   logic               ff;
   icc_pkg::act_type   act;

   always_comb begin
      md  = cur.mode;
      mc  = cur.minutes;
      fs  = cur.fill_start;
      ff  = cur.fall_flag;
      act = cur.act;

      // Events of the pass.
      if (req.minute_tick) mc = mc + icc_pkg::timer_type'(1);
      if (req.ice_fall)    ff = 1'b1;
      if (req.power_press) begin
         if (md == icc_pkg::MODE_OFF) begin
            md = icc_pkg::MODE_INIT;
         end else begin
            md  = icc_pkg::MODE_OFF;
            act = '0;
         end
      end

      unique case (md)
         icc_pkg::MODE_INIT: begin
            if (req.tank_full) begin
               mc = '0;
               md = icc_pkg::MODE_MAKING;
            end
         end
         icc_pkg::MODE_MAKING: begin
            if (icc_pkg::ext_timer(mc) < icc_pkg::ext_cfg(cfg.making_minutes)) begin
               // Hold the timer at zero until the evaporator is cold.
               if (req.low_side_temp > cfg.freeze_threshold) mc = '0;
               act[icc_pkg::ACT_HEAT] = 1'b0;
               act[icc_pkg::ACT_FAN]  = 1'b1;
               act[icc_pkg::ACT_COMP] = 1'b1;
               act[icc_pkg::ACT_PUMP] = 1'b1;
            end else begin
               act[icc_pkg::ACT_FAN]  = 1'b0;
               act[icc_pkg::ACT_COMP] = 1'b0;
               act[icc_pkg::ACT_PUMP] = 1'b0;
               mc = '0;
               ff = 1'b0;
               md = icc_pkg::MODE_RELEASE;
            end
         end
         icc_pkg::MODE_RELEASE: begin
            if (ff || (icc_pkg::ext_timer(mc) >= icc_pkg::ext_cfg(cfg.drop_timeout))) begin
               act[icc_pkg::ACT_HEAT] = 1'b0;
               ff = 1'b0;
               mc = '0;
               md = icc_pkg::MODE_MAKING;
            end else begin
               act[icc_pkg::ACT_HEAT] = 1'b1;
               act[icc_pkg::ACT_FAN]  = 1'b1;
               act[icc_pkg::ACT_COMP] = 1'b1;
            end
         end
         icc_pkg::MODE_NOWATER: begin
            act = '0;
            act[icc_pkg::ACT_LED] = 1'b1;
         end
         default: begin
            // Off, and any stray code: clear timers and the fall flag.
            md = icc_pkg::MODE_OFF;
            mc = '0;
            fs = '0;
            ff = 1'b0;
         end
      endcase

      // Tank fill, in init and making modes only. The timeout limit is one
      // bit wider than the timer and never wraps.
      fs_sum     = icc_pkg::ext_timer(mc) + icc_pkg::ext_cfg(cfg.fill_start_delay);
      fill_limit = icc_pkg::ext_timer(fs) + icc_pkg::ext_cfg(cfg.fill_timeout);
      if ((md == icc_pkg::MODE_INIT) || (md == icc_pkg::MODE_MAKING)) begin
         if (req.tank_full) begin
            act[icc_pkg::ACT_RES] = 1'b0;
            fs = fs_sum[icc_pkg::TIMER_WIDTH-1:0];
         end else if (icc_pkg::ext_timer(mc) >= fill_limit) begin
            act[icc_pkg::ACT_RES] = 1'b0;
            mc = '0;
            md = icc_pkg::MODE_NOWATER;
         end else if (mc >= fs) begin
            act[icc_pkg::ACT_RES] = 1'b1;
         end
      end

      nxt.mode       = md;
      nxt.minutes    = mc;
      nxt.fill_start = fs;
      nxt.fall_flag  = ff;
      nxt.act        = act;
   end

endmodule

/* sv/ice_cycle_controller_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ice_cycle_controller_core
// Ice machine cycle sequencer: one request is one control pass, one
// response carries the mode, six actuator bits and the minute counter.
// ---------------------------------------------------------------------------
//
//   channel   handshake              payload
//   req       req_valid / req_stall  tick, ice fall, power press, tank full, temp
//   rsp       rsp_valid / rsp_stall  mode, six actuator bits, minutes_now
//   csr       csr_write_en           csr_index, csr_wdata (8 bits)
//
// Flow: one request per cycle sustained while rsp_stall is low; a request passes
// through the input register, then the pass logic, into the response register.
// The pass logic (a few 9-bit compares and adds) sits between those two.
// Reset is synchronous and active high; it clears the sequencer state, the
// valid flags and the configuration registers to their defaults.
// A stalled response holds; req_stall rises only when the input register
// and the response register are both full and the response is stalled.
//
module ice_cycle_controller_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_minute_tick,
   input  logic                           req_ice_fall,
   input  logic                           req_power_press,
   input  logic                           req_tank_full,
   input  logic [7:0]                     req_low_side_temp,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_mode,
   output logic                           rsp_compressor_on,
   output logic                           rsp_pump_on,
   output logic                           rsp_fan_on,
   output logic                           rsp_heater_open,
   output logic                           rsp_reservoir_open,
   output logic                           rsp_low_water_led,
   output logic [icc_pkg::MIN_OUT_W-1:0]  rsp_minutes_now,

   input  logic                           csr_write_en,
   input  logic [icc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [icc_pkg::CFG_WIDTH-1:0]  csr_wdata
);

`include "ice_cycle_controller_core_defines.svh"

   icc_pkg::cfg_type    cfg;

   // Input register.
   logic                in_valid_ff;
   logic                in_valid_in;
   icc_pkg::req_type    in_req_ff;

   // Sequencer state.
   icc_pkg::state_type  state_ff;
   icc_pkg::state_type  state_in;

   // Response register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   icc_pkg::state_type  rsp_ff;

   logic                req_take;
   logic                out_free;
   logic                advance;

   icc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   icc_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (in_req_ff),
      .nxt (state_in)
   );

   // Response slot frees up when empty or taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Run the pass on the held request whenever the response slot is free.
   assign advance   = in_valid_ff && out_free;
   // Stall upstream only while the held request cannot move on.
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff.mode       <= icc_pkg::MODE_OFF;
         state_ff.minutes    <= '0;
         state_ff.fill_start <= '0;
         state_ff.fall_flag  <= 1'b0;
         state_ff.act        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Advance the sequencer once per pass.
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.minute_tick   <= req_minute_tick;
         in_req_ff.ice_fall      <= req_ice_fall;
         in_req_ff.power_press   <= req_power_press;
         in_req_ff.tank_full     <= req_tank_full;
         in_req_ff.low_side_temp <= req_low_side_temp;
      end
      if (advance) rsp_ff <= state_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = rsp_ff.mode;
   assign rsp_compressor_on  = rsp_ff.act[icc_pkg::ACT_COMP];
   assign rsp_pump_on        = rsp_ff.act[icc_pkg::ACT_PUMP];
   assign rsp_fan_on         = rsp_ff.act[icc_pkg::ACT_FAN];
   assign rsp_heater_open    = rsp_ff.act[icc_pkg::ACT_HEAT];
   assign rsp_reservoir_open = rsp_ff.act[icc_pkg::ACT_RES];
   assign rsp_low_water_led  = rsp_ff.act[icc_pkg::ACT_LED];
   assign rsp_minutes_now    = icc_pkg::minutes_out(rsp_ff.minutes);

   // A stalled request stays held in the input register.
   `ICC_ASSERT_NEXT(a_held_request, clock, reset, req_stall, in_valid_ff)
   // Upstream stalls only on response back-pressure.
   `ICC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid_ff && rsp_stall)
   // Off mode keeps the timer and fall flag cleared.
   `ICC_ASSERT_NOW(a_off_clear, clock, reset, state_ff.mode == icc_pkg::MODE_OFF,
      (state_ff.minutes == '0) && !state_ff.fall_flag)
   // The low water lamp is lit only in out-of-water mode.
   `ICC_ASSERT_NOW(a_led_mode, clock, reset, rsp_valid_ff && rsp_ff.act[icc_pkg::ACT_LED],
      rsp_ff.mode == icc_pkg::MODE_NOWATER)

endmodule
